FILE: src/efu_pkg.sv
// shared constants and types for the event flag unit
`timescale 1ns / 1ps
package efu_pkg;
    localparam int MAX_WAITERS_DEF = 8;
    localparam int FLAG_WIDTH_DEF  = 32;

    localparam logic [5:0] MODE_LEGAL      = 6'h31;
    localparam logic [5:0] MODE_CLEAR_BOTH = 6'h30;

    localparam logic [2:0] OP_SET     = 3'd0;
    localparam logic [2:0] OP_CLEAR   = 3'd1;
    localparam logic [2:0] OP_WAIT    = 3'd2;
    localparam logic [2:0] OP_POLL    = 3'd3;
    localparam logic [2:0] OP_CANCEL  = 3'd4;
    localparam logic [2:0] OP_TIMEOUT = 3'd5;
    localparam logic [2:0] OP_STATUS  = 3'd6;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_MODE  = 4'd1;
    localparam logic [3:0] ST_ZERO_PAT  = 4'd2;
    localparam logic [3:0] ST_MULTI     = 4'd3;
    localparam logic [3:0] ST_NO_MATCH  = 4'd4;
    localparam logic [3:0] ST_QUEUED    = 4'd5;
    localparam logic [3:0] ST_WOKEN     = 4'd6;
    localparam logic [3:0] ST_TIMED_OUT = 4'd7;
    localparam logic [3:0] ST_CANCELLED = 4'd8;
    localparam logic [3:0] ST_FULL      = 4'd9;
    localparam logic [3:0] ST_UNKNOWN   = 4'd10;

    localparam logic [2:0] ADDR_INIT_PAT = 3'd0;
    localparam logic [2:0] ADDR_ALLOW    = 3'd4;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  waiter;
        logic [31:0] pattern;
        logic [3:0]  count;
        logic        last;
    } result_t;
endpackage

FILE: src/event_flag_unit.sv
// event flag unit top level: controller around the waiter table memory
//
//  channel | direction | request
//  s_      | in        | opcode, bits_value, wait_mode, waiter_tag
//  m_      | out       | status, waiter_out, pattern_out, count_out (tdata), last (tlast)
//  cfg     | in        | apb writes of initial_pattern and allow_many_waiters
//
// table slots are read one at a time through the single read port of the memory, each
// evaluated before the next is read; clear, status, poll and wait do not walk the table
// cancel and timeout walk the queued waiters; set walks the waiters it examines
// each wake in set moves the younger waiters down one slot to close the gap
// synchronous active-low reset empties the table; the output register holds under stall
`timescale 1ns / 1ps
module event_flag_unit #(
    parameter int MAX_WAITERS = efu_pkg::MAX_WAITERS_DEF,
    parameter int FLAG_WIDTH  = efu_pkg::FLAG_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], bits_value[34:3], wait_mode[40:35], waiter_tag[48:41], zero fill
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[3:0], waiter_out[11:4], pattern_out[43:12], count_out[47:44]
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CW = $clog2(MAX_WAITERS + 1);
    localparam int DW = FLAG_WIDTH + 3 + 8;
    localparam int PW = (FLAG_WIDTH < 32) ? FLAG_WIDTH : 32;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_SHIFT_RD, S_SHIFT_WR, S_FINAL, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [FLAG_WIDTH-1:0] flag_reg, flag_next, bits_reg, bits_next;
    logic [31:0] init_reg, init_next;
    logic        allow_reg, allow_next;
    logic [CW-1:0] total_reg, total_next, idx_reg, idx_next, cnt_reg, cnt_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic [2:0]  op_reg, op_next;
    logic [5:0]  mode_reg, mode_next;
    logic [7:0]  tag_reg, tag_next;
    logic        remove_reg, remove_next;
    efu_pkg::result_t out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    efu_waiter_ram #(.DEPTH(MAX_WAITERS), .DW(DW), .AW(AW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic [FLAG_WIDTH-1:0] r_mask;
    logic [2:0] r_flags;
    logic [7:0] r_ident;
    assign r_mask  = rdata[FLAG_WIDTH-1:0];
    assign r_flags = rdata[FLAG_WIDTH+2:FLAG_WIDTH];
    assign r_ident = rdata[DW-1:FLAG_WIDTH+3];

    function automatic logic match_f(logic [FLAG_WIDTH-1:0] fl, logic [FLAG_WIDTH-1:0] m,
                                     logic orm);
        return orm ? ((fl & m) != '0) : ((fl & m) == m);
    endfunction

    function automatic logic [FLAG_WIDTH-1:0] clear_f(logic [FLAG_WIDTH-1:0] fl,
                                                     logic [FLAG_WIDTH-1:0] m, logic [2:0] f);
        logic [FLAG_WIDTH-1:0] r;
        r = fl;
        if (f[1]) r = '0;
        if (f[2]) r = r & ~m;
        return r;
    endfunction

    function automatic logic [3:0] cnt4(logic [CW-1:0] c);
        logic [CW+3:0] w;
        w = {4'd0, c};
        return (w > 15) ? 4'd15 : w[3:0];
    endfunction

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr)
            efu_pkg::ADDR_INIT_PAT: prdata = init_reg;
            default:                prdata = {31'd0, allow_reg};
        endcase
    end

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.count, out_reg.pattern, out_reg.waiter, out_reg.status};
    assign m_tlast  = out_reg.last;

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    logic [2:0] fenc;
    assign fenc = {mode_reg[5], mode_reg[4], mode_reg[0]};
    logic [FLAG_WIDTH-1:0] fl_eval, fl_clr;

    // memory addressing
    always_comb begin
        raddr = idx_reg[AW-1:0];
        we = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        if (state_reg == S_SHIFT_RD) raddr = AW'(idx_reg + 1'b1);
        if (state_reg == S_SHIFT_WR) we = 1'b1;
        if (state_reg == S_FINAL && op_reg == efu_pkg::OP_WAIT && remove_reg) begin
            we = 1'b1;
            waddr = total_reg[AW-1:0];
            wdata = {tag_reg, fenc, bits_reg};
        end
    end

    logic [FLAG_WIDTH-1:0] bits_in;
    assign bits_in = FLAG_WIDTH'(s_tdata[34:3]);
    assign fl_eval = flag_reg;
    assign fl_clr  = flag_reg & bits_reg;

    always_comb begin
        state_next = state_reg;
        flag_next = flag_reg;
        bits_next = bits_reg;
        init_next = init_reg;
        allow_next = allow_reg;
        total_next = total_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        walk_next = walk_reg;
        op_next = op_reg;
        mode_next = mode_reg;
        tag_next = tag_reg;
        remove_next = remove_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) out_valid_next = 1'b0;
        if (cfg_wr && paddr == efu_pkg::ADDR_INIT_PAT) begin
            init_next = pwdata;
            flag_next = FLAG_WIDTH'(pwdata);
        end
        if (cfg_wr && paddr == efu_pkg::ADDR_ALLOW) allow_next = pwdata[0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    op_next = s_tdata[2:0];
                    bits_next = bits_in;
                    mode_next = s_tdata[40:35];
                    tag_next = s_tdata[48:41];
                    idx_next = '0;
                    cnt_next = '0;
                    walk_next = '0;
                    remove_next = 1'b0;
                    if (s_tdata[2:0] == efu_pkg::OP_SET) begin
                        if (bits_in != '0) begin
                            flag_next = flag_reg | bits_in;
                            state_next = S_READ;
                        end else begin
                            state_next = S_FINAL;
                        end
                    end else if (s_tdata[2:0] == efu_pkg::OP_CANCEL ||
                                 s_tdata[2:0] == efu_pkg::OP_TIMEOUT) begin
                        state_next = S_READ;
                    end else begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_READ: begin
                if (idx_reg >= total_reg ||
                    (op_reg == efu_pkg::OP_SET && flag_reg == '0)) state_next = S_FINAL;
                else state_next = S_EVAL;
            end
            S_EVAL: begin
                if (out_free) begin
                    state_next = S_READ;
                    case (op_reg)
                        efu_pkg::OP_SET: begin
                            if (match_f(fl_eval, r_mask, r_flags[0])) begin
                                flag_next = clear_f(fl_eval, r_mask, r_flags);
                                out_next = '{efu_pkg::ST_WOKEN, r_ident,
                                             32'(fl_eval[PW-1:0]), 4'd0, 1'b0};
                                out_valid_next = 1'b1;
                                walk_next = idx_reg;
                                state_next = S_SHIFT_RD;
                            end else begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                        efu_pkg::OP_CANCEL: begin
                            out_next = '{efu_pkg::ST_CANCELLED, r_ident, 32'd0, 4'd0, 1'b0};
                            out_valid_next = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                            idx_next = idx_reg + 1'b1;
                        end
                        default: begin
                            if (r_ident == tag_reg) begin
                                remove_next = 1'b1;
                                state_next = S_SHIFT_RD;
                            end else begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT_RD: begin
                if (idx_reg + 1'b1 >= total_reg) begin
                    total_next = total_reg - 1'b1;
                    if (op_reg == efu_pkg::OP_SET) begin
                        idx_next = walk_reg;
                        state_next = S_READ;
                    end else begin
                        state_next = S_FINAL;
                    end
                end else begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                idx_next = idx_reg + 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_FINAL: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                    out_next = '{efu_pkg::ST_OK, 8'd0, 32'(flag_reg[PW-1:0]),
                                 cnt4(total_reg), 1'b1};
                    case (op_reg) inside
                        efu_pkg::OP_SET, efu_pkg::OP_STATUS: ;
                        efu_pkg::OP_CLEAR: begin
                            flag_next = fl_clr;
                            out_next.pattern = 32'(fl_clr[PW-1:0]);
                        end
                        efu_pkg::OP_CANCEL: begin
                            total_next = '0;
                            flag_next = bits_reg;
                            out_next.pattern = 32'(bits_reg[PW-1:0]);
                            out_next.count = cnt4(cnt_reg);
                        end
                        efu_pkg::OP_TIMEOUT: begin
                            out_next.pattern = 32'd0;
                            if (remove_reg) begin
                                out_next.status = efu_pkg::ST_TIMED_OUT;
                                out_next.waiter = tag_reg;
                            end else begin
                                out_next.status = efu_pkg::ST_UNKNOWN;
                            end
                        end
                        efu_pkg::OP_WAIT, efu_pkg::OP_POLL: begin
                            if (remove_reg) begin
                                out_next.status = efu_pkg::ST_QUEUED;
                                out_next.pattern = 32'd0;
                                out_next.count = cnt4(total_reg + 1'b1);
                                total_next = total_reg + 1'b1;
                            end else if ((mode_reg & ~efu_pkg::MODE_LEGAL) != 6'd0 ||
                                (mode_reg & efu_pkg::MODE_CLEAR_BOTH) ==
                                efu_pkg::MODE_CLEAR_BOTH) begin
                                out_next.status = efu_pkg::ST_BAD_MODE;
                                out_next.pattern = 32'd0;
                            end else if (bits_reg == '0) begin
                                out_next.status = efu_pkg::ST_ZERO_PAT;
                                out_next.pattern = 32'd0;
                            end else if (!allow_reg && total_reg != '0) begin
                                out_next.status = efu_pkg::ST_MULTI;
                                out_next.pattern = 32'd0;
                            end else if (match_f(flag_reg, bits_reg, fenc[0])) begin
                                flag_next = clear_f(flag_reg, bits_reg, fenc);
                            end else if (op_reg == efu_pkg::OP_POLL) begin
                                out_next.status = efu_pkg::ST_NO_MATCH;
                            end else if (total_reg >= CW'(MAX_WAITERS)) begin
                                out_next.status = efu_pkg::ST_FULL;
                                out_next.pattern = 32'd0;
                            end else begin
                                // queue: next cycle writes the slot and reports it together
                                out_valid_next = 1'b0;
                                remove_next = 1'b1;
                                state_next = S_FINAL;
                            end
                        end
                        default: begin
                            out_next.status = efu_pkg::ST_BAD_MODE;
                            out_next.pattern = 32'd0;
                        end
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            flag_reg <= '0;
            bits_reg <= '0;
            init_reg <= '0;
            allow_reg <= 1'b0;
            total_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            walk_reg <= '0;
            op_reg <= '0;
            mode_reg <= '0;
            tag_reg <= '0;
            remove_reg <= 1'b0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            flag_reg <= flag_next;
            bits_reg <= bits_next;
            init_reg <= init_next;
            allow_reg <= allow_next;
            total_reg <= total_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            walk_reg <= walk_next;
            op_reg <= op_next;
            mode_reg <= mode_next;
            tag_reg <= tag_next;
            remove_reg <= remove_next;
            out_reg <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

FILE: src/efu_waiter_ram.sv
// waiter table memory: one write port, one registered read port
`timescale 1ns / 1ps
module efu_waiter_ram #(
    parameter int DEPTH = efu_pkg::MAX_WAITERS_DEF,
    parameter int DW    = 43,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
